@@ rtl/bpa_pkg.sv @@
// Shared types and constants of the bitmap page allocator.
`default_nettype none
package bpa_pkg;

  // Fixed geometry of the bitmap and of a block
  localparam int unsigned BITS_PER_WORD = 32;
  localparam int unsigned BIT_W         = 5;
  localparam int unsigned BLOCK_BYTES   = 4096;
  localparam int unsigned BLOCK_SHIFT   = 12;

  // Request types
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Configuration register indexes
  localparam logic REG_BASE_BLOCK  = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [6:0]  count;
    logic [31:0] free_addr;
  } req_word_t;

  typedef struct packed {
    logic [31:0] block_addr;
    logic        addr_valid;
    logic        last;
    logic [1:0]  status;
    logic [6:0]  granted_total;
  } rsp_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr;
    logic accept;
    logic rd_issue;
    logic load;
    logic take;
    logic wr_back;
    logic free_rd;
    logic free_wr;
    logic fin;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_done;
    logic in_free;
    logic oob;
    logic scan_end;
    logic word_full;
    logic got_full;
    logic out_free;
    logic pend_v;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/bpa_ram.sv @@
// Generic single write port RAM with registered read.
`default_nettype none
module bpa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ rtl/bpa_ctrl.sv @@
// Controller state machine of the bitmap page allocator.
`default_nettype none
module bpa_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire bpa_pkg::sts_t sts_i,
  output bpa_pkg::cmd_t    cmd_o
);
  import bpa_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_A_RD  = 9'b000000100,
    S_A_LD  = 9'b000001000,
    S_A_SC  = 9'b000010000,
    S_F_CHK = 9'b000100000,
    S_F_WR  = 9'b001000000,
    S_FIN   = 9'b010000000,
    S_SPARE = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = sts_i.in_free ? S_F_CHK : S_A_RD;
        end
      end
      S_A_RD: begin
        if (sts_i.got_full || sts_i.scan_end) begin
          state_d = S_FIN;
        end else begin
          cmd_o.rd_issue = 1'b1;
          state_d = S_A_LD;
        end
      end
      S_A_LD: begin
        cmd_o.load = 1'b1;
        state_d = S_A_SC;
      end
      S_A_SC: begin
        if (sts_i.got_full || sts_i.word_full) begin
          cmd_o.wr_back = 1'b1;
          state_d = S_A_RD;
        end else if (!sts_i.pend_v || sts_i.out_free) begin
          cmd_o.take = 1'b1;
        end
      end
      S_F_CHK: begin
        if (sts_i.oob) begin
          state_d = S_FIN;
        end else begin
          cmd_o.free_rd = 1'b1;
          state_d = S_F_WR;
        end
      end
      S_F_WR: begin
        cmd_o.free_wr = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/bpa_dp.sv @@
// Datapath of the bitmap page allocator: bitmap RAM, scan registers, result words.
`default_nettype none
module bpa_dp #(
  parameter int unsigned BITMAP_WORDS = 1024,
  parameter int unsigned MAX_REQUEST  = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire bpa_pkg::cmd_t      cmd_i,
  output bpa_pkg::sts_t           sts_o,
  input  wire logic [19:0]        base_block_i,
  input  wire logic [15:0]        block_count_i,
  input  wire bpa_pkg::req_word_t in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output bpa_pkg::rsp_word_t      out_word_o
);
  import bpa_pkg::*;

  localparam int unsigned AW   = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int unsigned WW   = $clog2(BITMAP_WORDS + 1);
  localparam int unsigned CAP  = BITMAP_WORDS * BITS_PER_WORD;
  localparam int unsigned LW   = $clog2(CAP + 1);
  localparam int unsigned LCW  = (LW > 16) ? LW : 16;
  localparam int unsigned CW   = ((WW + BIT_W > LW) ? WW + BIT_W : LW) + 1;
  localparam int unsigned IW   = AW + BIT_W;
  localparam int unsigned FW   = (IW > 20) ? IW : 20;
  localparam int unsigned FCW  = (LW > 20) ? LW + 1 : 21;

  // Request registers
  logic              req_q;
  logic [6:0]        want_q, got_q;
  logic [31:0]       addr_q;
  logic [WW-1:0]     w_q;
  logic [BITS_PER_WORD-1:0] wd_q, lmask_q;
  logic [AW-1:0]     clr_q;
  rsp_word_t         pend_q;
  logic              pend_v_q;
  rsp_word_t         out_q;
  logic              out_v_q;
  logic [BITS_PER_WORD-1:0] rdata;

  // Effective block limit
  logic [LW-1:0] lim;
  always_comb begin
    if (LCW'(block_count_i) >= LCW'(CAP)) lim = LW'(CAP);
    else lim = LW'(block_count_i);
  end

  // Scan position against the limit
  logic [CW-1:0] wb, rem;
  logic          scan_end;
  logic [BITS_PER_WORD-1:0] lmask;
  always_comb begin
    wb       = CW'({w_q, {BIT_W{1'b0}}});
    rem      = CW'(lim) - wb;
    scan_end = (w_q == WW'(BITMAP_WORDS)) || (wb >= CW'(lim));
    for (int b = 0; b < BITS_PER_WORD; b++) begin
      lmask[b] = (CW'(b) >= rem);
    end
  end

  // Lowest free bit of the loaded word
  logic [BITS_PER_WORD-1:0] eff;
  logic [BIT_W-1:0] pos;
  always_comb begin
    eff = wd_q | lmask_q;
    pos = '0;
    for (int i = BITS_PER_WORD - 1; i >= 0; i--) begin
      if (!eff[i]) pos = BIT_W'(i);
    end
  end

  logic [IW-1:0] tidx;
  logic [31:0]   taddr;
  assign tidx  = {w_q[AW-1:0], pos};
  assign taddr = (32'(tidx) + 32'(base_block_i)) << BLOCK_SHIFT;

  // Free request range check
  logic [19:0]   frame, diff;
  logic [FW-1:0] diff_x;
  logic [IW-1:0] fidx;
  logic          oob;
  assign frame  = addr_q[31:BLOCK_SHIFT];
  assign diff   = frame - base_block_i;
  assign diff_x = FW'(diff);
  assign fidx   = diff_x[IW-1:0];
  assign oob    = (frame < base_block_i) || (FCW'(diff) >= FCW'(lim));

  // Final status of the request
  logic [1:0] fin_st;
  always_comb begin
    if (req_q == REQ_FREE) fin_st = oob ? ST_RANGE : ST_OK;
    else fin_st = (got_q < want_q) ? ST_SHORT : ST_OK;
  end

  // Final result word: the pending grant, or an empty word
  rsp_word_t last_word;
  always_comb begin
    last_word        = pend_q;
    last_word.last   = 1'b1;
    last_word.status = fin_st;
    if (!pend_v_q) begin
      last_word.block_addr    = '0;
      last_word.addr_valid    = 1'b0;
      last_word.granted_total = '0;
    end
  end

  logic out_free;
  assign out_free = !out_v_q || !out_stall_i;

  // Bitmap RAM ports
  logic                     we;
  logic [AW-1:0]            waddr, raddr;
  logic [BITS_PER_WORD-1:0] wdata;
  always_comb begin
    we    = cmd_i.clr | cmd_i.wr_back | cmd_i.free_wr;
    waddr = clr_q;
    wdata = '0;
    if (cmd_i.wr_back) begin
      waddr = w_q[AW-1:0];
      wdata = wd_q;
    end else if (cmd_i.free_wr) begin
      waddr = fidx[IW-1:BIT_W];
      wdata = rdata & ~(BITS_PER_WORD'(1) << fidx[BIT_W-1:0]);
    end
    raddr = cmd_i.free_rd ? fidx[IW-1:BIT_W] : w_q[AW-1:0];
  end

  bpa_ram #(
    .WIDTH(BITS_PER_WORD),
    .DEPTH(BITMAP_WORDS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      got_q    <= '0;
      want_q   <= '0;
      w_q      <= '0;
      req_q    <= REQ_ALLOC;
    end else begin
      if (cmd_i.clr) clr_q <= clr_q + AW'(1);
      if (cmd_i.accept) begin
        req_q    <= in_word_i.req_type;
        want_q   <= (in_word_i.count > 7'(MAX_REQUEST)) ? 7'(MAX_REQUEST) : in_word_i.count;
        got_q    <= '0;
        w_q      <= '0;
        pend_v_q <= 1'b0;
      end
      if (cmd_i.take) begin
        got_q    <= got_q + 7'd1;
        pend_v_q <= 1'b1;
      end
      if (cmd_i.wr_back) w_q <= w_q + WW'(1);
      if (cmd_i.fin) pend_v_q <= 1'b0;
      // Output word register
      if ((cmd_i.take && pend_v_q) || cmd_i.fin) out_v_q <= 1'b1;
      else if (!out_stall_i) out_v_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) addr_q <= in_word_i.free_addr;
    if (cmd_i.load) begin
      wd_q    <= rdata;
      lmask_q <= lmask;
    end
    if (cmd_i.take) begin
      wd_q[pos]            <= 1'b1;
      pend_q.block_addr    <= taddr;
      pend_q.addr_valid    <= 1'b1;
      pend_q.last          <= 1'b0;
      pend_q.status        <= ST_OK;
      pend_q.granted_total <= got_q + 7'd1;
      if (pend_v_q) out_q <= pend_q;
    end
    if (cmd_i.fin) out_q <= last_word;
  end

  // Status to the controller
  always_comb begin
    sts_o.clr_done  = (clr_q == AW'(BITMAP_WORDS - 1));
    sts_o.in_free   = (in_word_i.req_type == REQ_FREE);
    sts_o.oob       = oob;
    sts_o.scan_end  = scan_end;
    sts_o.word_full = &eff;
    sts_o.got_full  = (got_q == want_q);
    sts_o.out_free  = out_free;
    sts_o.pend_v    = pend_v_q;
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

endmodule
`default_nettype wire

@@ rtl/bitmap_page_allocator_unit.sv @@
// Top level of the bitmap page allocator: configuration port, controller, datapath.
`default_nettype none
// First-fit page-frame allocator over a bitmap of 4 KiB blocks held in one RAM of
// BITMAP_WORDS 32-bit words (1 = used). An allocate word scans the bitmap a word at a
// time and returns one result word per granted block, the final one flagged last, or
// one empty word when none is granted; a free word returns a single result. The bitmap
// RAM has a single write port and a registered read port; the grant step takes one bit
// per cycle while the output is not stalled. An allocate visits each bitmap word in a
// read, a load and a scan state; a free reads and writes back one bitmap word, or skips
// the RAM when its address is out of range. After reset the bitmap is cleared in one
// pass that accepts no request; configuration writes are taken at any time.
module bitmap_page_allocator_unit #(
  parameter int unsigned BITMAP_WORDS = 1024,
  parameter int unsigned MAX_REQUEST  = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire bpa_pkg::req_word_t in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output bpa_pkg::rsp_word_t      out_word_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import bpa_pkg::*;

  logic [19:0] base_block_q;
  logic [15:0] block_count_q;
  cmd_t        cmd;
  sts_t        sts;
  logic        wr_en;

  // Configuration registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[1:0] == 2'b00);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_block_q  <= '0;
      block_count_q <= 16'd32768;
    end else if (wr_en) begin
      if (paddr[2] == REG_BASE_BLOCK) base_block_q <= pwdata[19:0];
      if (paddr[2] == REG_BLOCK_COUNT) block_count_q <= pwdata[15:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_BASE_BLOCK) prdata = 32'(base_block_q);
    else prdata = 32'(block_count_q);
  end

  bpa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  bpa_dp #(
    .BITMAP_WORDS(BITMAP_WORDS),
    .MAX_REQUEST (MAX_REQUEST)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .base_block_i (base_block_q),
    .block_count_i(block_count_q),
    .in_word_i    (in_word_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_o   (out_word_o)
  );

`ifndef SYNTH
  // A range error never carries a block and always ends the request
  a_range_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == ST_RANGE |-> out_word_o.last && !out_word_o.addr_valid)
    else $error("range status on a granted or non-final word");
  // Only the final word of a request can be empty
  a_mid_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.last |-> out_word_o.addr_valid)
    else $error("non-final word without a granted block");
  // A granted word counts at least one and at most the request limit
  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.addr_valid |->
      out_word_o.granted_total != 7'd0 && out_word_o.granted_total <= 7'(MAX_REQUEST))
    else $error("granted total out of range");
  // No request is taken while a controller command is busy with the bitmap
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !cmd.clr && !cmd.take && !cmd.wr_back && !cmd.free_wr)
    else $error("request accepted while busy");
`endif

endmodule
`default_nettype wire

@@ tb/bitmap_page_allocator_unit_tb.sv @@
// Testbench for the bitmap page allocator: random alloc/free words checked against a bitmap model.
`timescale 1ns / 100ps
module bitmap_page_allocator_unit_tb;
  import bpa_pkg::*;

  localparam int unsigned WORDS    = 1024;
  localparam int unsigned MAX_REQ  = 64;
  localparam int unsigned CAPACITY = WORDS * BITS_PER_WORD;
  localparam int unsigned LIMIT    = 20000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_word_t out_word_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bitmap_page_allocator_unit #(.BITMAP_WORDS(WORDS), .MAX_REQUEST(MAX_REQ)) u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i, .out_valid_o, .out_stall_i,
    .out_word_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state
  logic [BITS_PER_WORD-1:0] page_map [WORDS];
  logic [19:0] base_frame;
  logic [15:0] managed_blocks;

  req_word_t pending_words[$];
  rsp_word_t expected_grants[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit quiet_send = 0, quiet_recv = 0;
  bit in_done = 0;
  int unsigned hold_left = 0;

  // Works out the results of one accepted word and updates the page map
  function automatic void predict_grants(req_word_t w);
    rsp_word_t r;
    int unsigned lim, want, got;
    logic [31:0] frame;
    lim = (managed_blocks < CAPACITY) ? managed_blocks : CAPACITY;
    r = '0;
    r.last = 1'b1;
    if (w.req_type == REQ_FREE) begin
      frame = w.free_addr >> BLOCK_SHIFT;
      if (frame < base_frame || frame - base_frame >= lim) begin
        r.status = ST_RANGE;
      end else begin
        page_map[(frame - base_frame) / BITS_PER_WORD][(frame - base_frame) % BITS_PER_WORD] = 1'b0;
        r.status = ST_OK;
      end
      expected_grants.push_back(r);
      return;
    end
    want = (w.count > MAX_REQ) ? MAX_REQ : w.count;
    if (want == 0) begin
      r.status = ST_OK;
      expected_grants.push_back(r);
      return;
    end
    got = 0;
    for (int unsigned i = 0; i < lim && got < want; i++) begin
      if (!page_map[i / BITS_PER_WORD][i % BITS_PER_WORD]) begin
        page_map[i / BITS_PER_WORD][i % BITS_PER_WORD] = 1'b1;
        got++;
        r = '0;
        r.block_addr = (32'(i) + 32'(base_frame)) << BLOCK_SHIFT;
        r.addr_valid = 1'b1;
        r.last = (got == want);
        r.status = ST_OK;
        r.granted_total = 7'(got);
        expected_grants.push_back(r);
      end
    end
    if (got == 0) begin
      r = '0;
      r.last = 1'b1;
      r.status = ST_SHORT;
      expected_grants.push_back(r);
    end else if (got < want) begin
      r = expected_grants.pop_back();
      r.last = 1'b1;
      r.status = ST_SHORT;
      expected_grants.push_back(r);
    end
  endfunction

  // Driver: offers queued words, changes at the falling edge; a word waits until taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_done) begin
        if (pending_words.size() > 0 && (quiet_send || $urandom_range(99) >= 12)) begin
          in_word_i <= pending_words[0];
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus a long counted hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left <= hold_left - 1;
      end else begin
        out_stall_i <= !quiet_recv && ($urandom_range(99) < 12);
      end
    end
  end

  // Acceptance of input words, at the rising edge
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    in_done <= in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o) begin
      predict_grants(in_word_i);
      void'(pending_words.pop_front());
    end
  end

  // Monitor: compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    rsp_word_t e;
    if (out_valid_o && !out_stall_i) begin
      if (expected_grants.size() == 0) begin
        $error("unexpected result word %p", out_word_o);
        errors++;
      end else begin
        e = expected_grants.pop_front();
        if (out_word_o.block_addr !== e.block_addr) begin
          $error("block_addr exp %h got %h", e.block_addr, out_word_o.block_addr); errors++;
        end
        if (out_word_o.addr_valid !== e.addr_valid) begin
          $error("addr_valid exp %b got %b", e.addr_valid, out_word_o.addr_valid); errors++;
        end
        if (out_word_o.last !== e.last) begin
          $error("last exp %b got %b", e.last, out_word_o.last); errors++;
        end
        if (out_word_o.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_word_o.status); errors++;
        end
        if (out_word_o.granted_total !== e.granted_total) begin
          $error("granted_total exp %0d got %0d", e.granted_total, out_word_o.granted_total);
          errors++;
        end
      end
    end
  end

  // Timeout guard
  always @(posedge clk_i) begin
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_BASE_BLOCK) base_frame = val[19:0];
    else managed_blocks = val[15:0];
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || expected_grants.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic req_word_t make_alloc(int unsigned n);
    req_word_t w;
    w = '0;
    w.req_type = REQ_ALLOC;
    w.count = 7'(n);
    w.free_addr = $urandom;
    return w;
  endfunction

  function automatic req_word_t make_free(logic [31:0] a);
    req_word_t w;
    w.req_type = REQ_FREE;
    w.count = 7'($urandom);
    w.free_addr = a;
    return w;
  endfunction

  // Frame near the managed region, mostly inside it
  function automatic logic [31:0] near_addr();
    int unsigned off;
    off = $urandom_range(managed_blocks + 4);
    return ((32'(base_frame) + off) << BLOCK_SHIFT) | 32'($urandom_range(4095));
  endfunction

  task automatic random_phase(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: pending_words.push_back(make_alloc($urandom_range(127)));
        1, 2, 3: pending_words.push_back(make_alloc($urandom_range(1, 12)));
        4: pending_words.push_back(make_free($urandom));
        default: pending_words.push_back(make_free(near_addr()));
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < WORDS; i++) page_map[i] = '0;
    base_frame = '0;
    managed_blocks = 16'd32768;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Small region so exhaustion and shortfall occur
    write_reg(REG_BLOCK_COUNT, 32'd40);
    write_reg(REG_BASE_BLOCK, 32'h000FFFFF);
    pending_words.push_back(make_alloc(0));
    pending_words.push_back(make_alloc(1));
    pending_words.push_back(make_alloc(MAX_REQ));
    pending_words.push_back(make_alloc(127));
    pending_words.push_back(make_free(32'hFFFFF000));
    pending_words.push_back(make_free(32'hFFFFF123));
    pending_words.push_back(make_free(32'hFFFFF123));
    pending_words.push_back(make_free(32'h00000000));
    pending_words.push_back(make_free(32'hFFFFFFFF));
    pending_words.push_back(make_alloc(3));
    pending_words.push_back(make_free(32'h7FFFFFFF));
    drain();

    write_reg(REG_BASE_BLOCK, 32'd0);
    write_reg(REG_BLOCK_COUNT, 32'd0);
    pending_words.push_back(make_alloc(5));
    pending_words.push_back(make_free(32'h0));
    drain();

    // Back-pressure: receiver holds off while sender keeps offering
    write_reg(REG_BLOCK_COUNT, 32'd100);
    write_reg(REG_BASE_BLOCK, 32'd1234);
    quiet_send = 1;
    hold_left = 400;
    for (int i = 0; i < 8; i++) pending_words.push_back(make_alloc(4));
    drain();
    quiet_send = 0;
    random_phase(80);
    drain();

    write_reg(REG_BLOCK_COUNT, 32'hFFFF);
    write_reg(REG_BASE_BLOCK, 32'h000ABCDE);
    quiet_send = 1; quiet_recv = 1;
    random_phase(40);
    drain();
    quiet_send = 0; quiet_recv = 0;
    random_phase(40);
    drain();

    write_reg(REG_BLOCK_COUNT, 32'd33);
    write_reg(REG_BASE_BLOCK, 32'd7);
    random_phase(90);
    drain();

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
